FILE: rtl/core/lrupr_pkg.sv
package lrupr_pkg;

  // Reset value of the frame limit register.
  localparam logic [4:0] LIMIT_RESET = 5'd16;

  // Command broadcast to every cell for one reference.
  typedef struct packed {
    logic upd;   // a reference word is being taken this cycle
    logic hit;   // the page is resident somewhere in the row
    logic fill;  // miss that goes into the first empty frame
  } lrupr_ctl_t;

  // What one cell reports about itself for the current reference.
  typedef struct packed {
    logic match;      // holds the referenced page
    logic victim;     // holds the least recently used page
    logic fill_slot;  // first empty frame of the row
  } lrupr_stat_t;

endpackage

FILE: rtl/core/lru_page_replacement_unit.sv
// Least recently used page replacement over a fully associative row of frames.
// Input channel (in_valid/in_ready/in_page_number): one page reference per word.
// Result channel (out_valid/out_ready/out_*): exactly one result word per reference,
// giving hit or fault, the frame now holding the page, the evicted page on a
// replacement and the saturating fault total.
// Configuration channel (cfg_valid/cfg_ready/cfg_frames_in_use): the frame limit;
// cfg_ready is always high, and it should only be written while the block is idle.
// Each frame is a cell that compares its page against the reference and keeps its
// own recency rank; the cells all update in the same cycle as the word is taken.
// out_valid rises in the cycle after acceptance, and a new reference can be taken
// every cycle: the result register frees as soon as out_ready is high.
// While the receiver stalls, the held result stays put and in_ready drops, so no
// further references are taken until it is collected.
// Reset empties every frame, clears the fault count and sets the limit to 16.
module lru_page_replacement_unit
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAGE_BITS-1:0] in_page_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_fault,
  output logic [3:0]           out_frame_index,
  output logic                 out_evicted_valid,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [31:0]          out_fault_total,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [4:0]           cfg_frames_in_use
);

  localparam int IDX_W = $clog2((FRAMES > 1) ? FRAMES : 2);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

  logic [4:0]           limit_r;
  logic [CNT_W-1:0]     filled_r, filled_nxt;
  logic [31:0]          fault_cnt_r, fault_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 fault_r;
  logic [3:0]           frame_idx_r;
  logic                 ev_valid_r;
  logic [PAGE_BITS-1:0] ev_page_r;

  logic                 accept;
  lrupr_ctl_t           ctl;
  logic [FRAMES:0]      valid_chain;
  logic [IDX_W-1:0]     rank_vec [FRAMES];
  logic [PAGE_BITS-1:0] page_vec [FRAMES];
  lrupr_stat_t          stat_vec [FRAMES];
  logic [FRAMES-1:0]    match_vec, victim_vec;

  logic                 hit_any;
  logic [IDX_W-1:0]     hit_rank, hit_idx, victim_idx, old_rank, sel_idx;
  logic [PAGE_BITS-1:0] victim_page;
  logic [CNT_W-1:0]     filled_m1;
  logic [LIM_W-1:0]     lim_eff;
  logic                 fill_ok;
  logic [IDX_W+3:0]     idx_ext;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign filled_m1 = filled_r - 1'b1;
  assign old_rank  = filled_m1[IDX_W-1:0];
  assign valid_chain[0] = 1'b1;

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      lrupr_cell #(
        .PAGE_BITS (PAGE_BITS),
        .RANK_W    (IDX_W)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_i        (ctl),
        .page_i       (in_page_number),
        .hit_rank_i   (hit_rank),
        .old_rank_i   (old_rank),
        .prev_valid_i (valid_chain[g]),
        .valid_o      (valid_chain[g+1]),
        .rank_o       (rank_vec[g]),
        .page_o       (page_vec[g]),
        .stat_o       (stat_vec[g])
      );
      assign match_vec[g]  = stat_vec[g].match;
      assign victim_vec[g] = stat_vec[g].victim;
    end
  endgenerate

  // Resident pages are unique, so at most one cell matches and OR-ing is enough.
  always_comb begin
    hit_rank    = '0;
    hit_idx     = '0;
    victim_idx  = '0;
    victim_page = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (match_vec[i]) begin
        hit_rank = hit_rank | rank_vec[i];
        hit_idx  = hit_idx | IDX_W'(i);
      end
      if (victim_vec[i]) begin
        victim_idx  = victim_idx | IDX_W'(i);
        victim_page = victim_page | page_vec[i];
      end
    end
  end

  assign hit_any = |match_vec;

  always_comb begin
    if (limit_r == '0) begin
      lim_eff = LIM_W'(1);
    end else if (LIM_W'(limit_r) > LIM_W'(FRAMES)) begin
      lim_eff = LIM_W'(FRAMES);
    end else begin
      lim_eff = LIM_W'(limit_r);
    end
  end

  assign fill_ok = LIM_W'(filled_r) < lim_eff;

  always_comb begin
    ctl.upd  = accept;
    ctl.hit  = hit_any;
    ctl.fill = !hit_any && fill_ok;
  end

  always_comb begin
    if (hit_any) begin
      sel_idx = hit_idx;
    end else if (fill_ok) begin
      sel_idx = filled_r[IDX_W-1:0];
    end else begin
      sel_idx = victim_idx;
    end
    idx_ext = {4'b0000, sel_idx};
  end

  always_comb begin
    filled_nxt    = filled_r;
    fault_cnt_nxt = fault_cnt_r;
    if (accept && !hit_any) begin
      if (fault_cnt_r != '1) begin
        fault_cnt_nxt = fault_cnt_r + 1'b1;
      end
      if (fill_ok) begin
        filled_nxt = filled_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      filled_r    <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_frames_in_use;
      end
      filled_r    <= filled_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fault_r     <= !hit_any;
      frame_idx_r <= idx_ext[3:0];
      ev_valid_r  <= !hit_any && !fill_ok;
      ev_page_r   <= (!hit_any && !fill_ok) ? victim_page : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fault         = fault_r;
  assign out_frame_index   = frame_idx_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_page  = ev_page_r;
  assign out_fault_total   = fault_cnt_r;

  // Resident pages never repeat, so a reference matches one frame at most.
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one frame holds the referenced page");

  // Ranks form a permutation, so at most one frame can be the oldest.
  a_victim_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(victim_vec))
    else $error("more than one frame carries the oldest rank");

  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (LIM_W'(filled_r) <= LIM_W'(FRAMES)))
    else $error("filled frame count beyond the frame row");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid && (out_fault_total >= $past(fault_cnt_r))))
    else $error("accepted reference produced no result word");

endmodule

FILE: rtl/core/lrupr_cell.sv
module lrupr_cell
  import lrupr_pkg::*;
#(
  parameter int PAGE_BITS = 16,
  parameter int RANK_W    = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lrupr_ctl_t           ctl_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [RANK_W-1:0]    hit_rank_i,
  input  logic [RANK_W-1:0]    old_rank_i,
  input  logic                 prev_valid_i,
  output logic                 valid_o,
  output logic [RANK_W-1:0]    rank_o,
  output logic [PAGE_BITS-1:0] page_o,
  output lrupr_stat_t          stat_o
);

  logic                 valid_r, valid_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  lrupr_stat_t          stat;

  always_comb begin
    stat.match     = valid_r && (page_r == page_i);
    stat.victim    = valid_r && (rank_r == old_rank_i);
    // Frames fill from the low end, so the first empty one follows a full neighbour.
    stat.fill_slot = !valid_r && prev_valid_i;
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    page_nxt  = page_r;
    if (ctl_i.upd) begin
      if (ctl_i.hit) begin
        if (stat.match) begin
          rank_nxt = '0;
        end else if (valid_r && (rank_r < hit_rank_i)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end else if (ctl_i.fill) begin
        if (stat.fill_slot) begin
          valid_nxt = 1'b1;
          page_nxt  = page_i;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end else begin
        if (stat.victim) begin
          page_nxt = page_i;
          rank_nxt = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    page_r <= page_nxt;
  end

  assign valid_o = valid_r;
  assign rank_o  = rank_r;
  assign page_o  = page_r;
  assign stat_o  = stat;

endmodule

FILE: tb/sv/lru_page_replacement_checker.sv
`timescale 1ns / 1ps

module lru_page_replacement_checker
  import lrupr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_page_number,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_fault,
  input  logic [3:0]  out_frame_index,
  input  logic        out_evicted_valid,
  input  logic [15:0] out_evicted_page,
  input  logic [31:0] out_fault_total,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_frames_in_use,
  output int          fail_count,
  output int          outstanding
);

  localparam int FRAME_SLOTS = 16;

  typedef struct packed {
    logic        fault;
    logic [3:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [31:0] fault_total;
  } page_result_t;

  page_result_t pending_results[$];

  logic [15:0] resident_page [FRAME_SLOTS];
  logic [3:0]  age_rank [FRAME_SLOTS];
  logic [4:0]  filled_count;
  logic [31:0] fault_tally;
  logic [4:0]  frame_limit;
  int          mismatches = 0;

  // Every filled frame younger than the bound grows one step older, and the
  // touched frame becomes the most recent.
  function automatic void make_recent(input int slot, input int bound);
    int i;
    for (i = 0; i < FRAME_SLOTS; i++) begin
      if (i < int'(filled_count) && i != slot && int'(age_rank[i]) < bound)
        age_rank[i] = age_rank[i] + 4'd1;
    end
    age_rank[slot] = 4'd0;
  endfunction

  function automatic page_result_t lru_reference(input logic [15:0] page);
    page_result_t res;
    int           usable;
    int           hit_at;
    int           slot;
    int           i;
    usable = int'(frame_limit);
    if (usable < 1)
      usable = 1;
    if (usable > FRAME_SLOTS)
      usable = FRAME_SLOTS;
    res = '0;
    hit_at = -1;
    for (i = 0; i < int'(filled_count); i++) begin
      if (hit_at < 0 && resident_page[i] == page)
        hit_at = i;
    end
    if (hit_at >= 0) begin
      slot = hit_at;
      make_recent(slot, int'(age_rank[slot]));
    end else begin
      res.fault = 1'b1;
      if (fault_tally != 32'hFFFF_FFFF)
        fault_tally = fault_tally + 32'd1;
      if (int'(filled_count) < usable) begin
        slot = int'(filled_count);
        filled_count = filled_count + 5'd1;
      end else begin
        // With the limit lowered, the victim is still chosen among every
        // frame that was ever filled.
        slot = 0;
        for (i = 1; i < int'(filled_count); i++) begin
          if (age_rank[i] > age_rank[slot])
            slot = i;
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = resident_page[slot];
      end
      resident_page[slot] = page;
      make_recent(slot, FRAME_SLOTS);
    end
    res.frame_index = slot[3:0];
    res.fault_total = fault_tally;
    return res;
  endfunction

  always @(posedge clk) begin
    page_result_t got;
    page_result_t want;
    if (!rst_n) begin
      pending_results.delete();
      filled_count = '0;
      fault_tally  = '0;
      frame_limit  = LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready)
        frame_limit = cfg_frames_in_use;
      // The result word leaving now belongs to an earlier reference, so it is
      // checked before this edge's reference is predicted.
      if (out_valid && out_ready) begin
        got = {out_fault, out_frame_index, out_evicted_valid, out_evicted_page,
               out_fault_total};
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word with nothing expected: %h", $time, got);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.fault !== want.fault || got.frame_index !== want.frame_index ||
              got.evicted_valid !== want.evicted_valid ||
              got.evicted_page !== want.evicted_page ||
              got.fault_total !== want.fault_total) begin
            if (mismatches < 10) begin
              $display("%0t: expected fault=%0d frame=%0d evicted=%0d page=%h total=%0d",
                       $time, want.fault, want.frame_index, want.evicted_valid,
                       want.evicted_page, want.fault_total);
              $display("%0t:      got fault=%0d frame=%0d evicted=%0d page=%h total=%0d",
                       $time, got.fault, got.frame_index, got.evicted_valid,
                       got.evicted_page, got.fault_total);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_results.insert(pending_results.size(), lru_reference(in_page_number));
    end
    fail_count  <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/sv/tb_lru_page_replacement_unit.sv
`timescale 1ns / 1ps

module tb_lru_page_replacement_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORKLOAD_LEN = 165;
  // Frame limits of the random phases; the last entry listed sits at index 0.
  localparam logic [7:0][4:0] WORKLOAD_LIMITS =
    {5'd20, 5'd4, 5'd13, 5'd16, 5'd0, 5'd31, 5'd11, 5'd6};

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_page_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_fault;
  logic [3:0]  out_frame_index;
  logic        out_evicted_valid;
  logic [15:0] out_evicted_page;
  logic [31:0] out_fault_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_frames_in_use = '0;
  int          fail_count;
  int          outstanding;
  logic        calm = 1'b0;
  int unsigned stall_left = 0;
  int          cycle_count = 0;

  lru_page_replacement_unit dut (.*);

  lru_page_replacement_checker watch (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver holds off in bursts, except in the closing stretch.
  always @(posedge clk) begin
    if (calm)
      stall_left = 0;
    else if (stall_left != 0)
      stall_left = stall_left - 1;
    else if ($urandom_range(0, 11) == 0)
      stall_left = $urandom_range(1, 19);
    out_ready <= (stall_left == 0);
  end

  task automatic send_reference(input logic [15:0] page);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (!in_ready);
  endtask

  // One edge is let pass first so that the count already includes the last
  // word taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_frame_limit(input logic [4:0] limit);
    cfg_valid         <= 1'b1;
    cfg_frames_in_use <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly references from a small working set, so that hits, fills and
  // replacements all happen, with some fully random pages mixed in.
  task automatic run_workload(input int count);
    logic [15:0] pool [24];
    int          pool_size;
    int          n;
    pool_size = $urandom_range(2, 24);
    for (n = 0; n < 24; n++)
      pool[n] = 16'($urandom);
    for (n = 0; n < count; n++) begin
      if (!calm && $urandom_range(0, 119) == 0)
        wait_for_results();
      if ($urandom_range(0, 15) == 0)
        pool[$urandom_range(0, pool_size - 1)] = 16'($urandom);
      if ($urandom_range(0, 4) == 0)
        send_reference(16'($urandom));
      else
        send_reference(pool[$urandom_range(0, pool_size - 1)]);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // A limit of zero behaves as a single frame.
    write_frame_limit(5'd0);
    send_reference(16'h0000); send_reference(16'h0000); send_reference(16'hFFFF);
    send_reference(16'hFFFF); send_reference(16'h8000); send_reference(16'h0001);
    wait_for_results();

    write_frame_limit(5'd3);
    send_reference(16'h1234); send_reference(16'h5678); send_reference(16'h1234);
    send_reference(16'h0001); send_reference(16'hAAAA); send_reference(16'h5555);
    send_reference(16'h5678);
    wait_for_results();

    // Limit below the filled count: all filled frames stay in play.
    write_frame_limit(5'd2);
    send_reference(16'h0F0F); send_reference(16'h5555); send_reference(16'hF0F0);
    send_reference(16'h0F0F);
    wait_for_results();

    // A limit above the frame count behaves as the full row.
    write_frame_limit(5'd17);
    send_reference(16'h7FFF); send_reference(16'h0002); send_reference(16'h7FFF);
    send_reference(16'h0003);

    for (int p = 0; p < 8; p++) begin
      wait_for_results();
      if (p == 7)
        calm <= 1'b1;
      write_frame_limit(WORKLOAD_LIMITS[p]);
      run_workload(WORKLOAD_LEN);
    end

    wait_for_results();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
